// File: src/gbn_pkg.sv
// Shared types, codes and constants of the Go-Back-N sender.
package gbn_pkg;

  localparam int unsigned PacketBytes = 1024;
  localparam int unsigned MaxWindow   = 32;
  localparam int unsigned CmdDepth    = 2;

  localparam int unsigned SeqW   = 16;
  localparam int unsigned TotalW = 24;
  localparam int unsigned TriesW = 8;
  localparam int unsigned WinW   = 7;
  localparam int unsigned TailW  = 17;

  localparam logic [1:0] FuncPoll    = 2'd0;
  localparam logic [1:0] FuncAck     = 2'd1;
  localparam logic [1:0] FuncTimeout = 2'd2;

  localparam logic [1:0] KindDesc   = 2'd0;
  localparam logic [1:0] KindAck    = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  localparam logic [1:0] CfgWindow = 2'd0;
  localparam logic [1:0] CfgTotal  = 2'd1;
  localparam logic [1:0] CfgTries  = 2'd2;

  localparam logic [5:0]  WindowReset = 6'd5;
  localparam logic [7:0]  TriesReset  = 8'd8;
  localparam logic [7:0]  TriesSat    = 8'hFF;

  typedef enum logic [1:0] {
    CMD_POLL,
    CMD_ACK,
    CMD_TIMEOUT,
    CMD_IDLE
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    logic [15:0] ack;
  } cmd_t;

  typedef struct packed {
    logic [5:0]       window_size;
    logic [23:0]      total_length;
    logic [7:0]       max_tries;
    logic [23:0]      last_index;
    logic [TailW-1:0] tail_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq_number;
    logic [23:0] byte_offset;
    logic [10:0] length;
    logic        start_timer;
    logic        stop_timer;
    logic        accepted;
    logic        complete;
    logic        give_up;
    logic        last;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_POLL
  } back_state_e;

endpackage

// File: src/gbn_if.sv
// Channel interfaces: event input, result output and register write port.
interface gbn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] ack_number;

  modport source (output valid, func, ack_number, input ready);
  modport sink (input valid, func, ack_number, output ready);
endinterface

interface gbn_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] seq_number;
  logic [23:0] byte_offset;
  logic [10:0] length;
  logic        start_timer;
  logic        stop_timer;
  logic        accepted;
  logic        complete;
  logic        give_up;
  logic        last;

  modport source (
    output valid, kind, seq_number, byte_offset, length, start_timer, stop_timer,
           accepted, complete, give_up, last,
    input  ready
  );
  modport sink (
    input  valid, kind, seq_number, byte_offset, length, start_timer, stop_timer,
           accepted, complete, give_up, last,
    output ready
  );
endinterface

interface gbn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/gbn_cfg.sv
// Configuration registers and the reciprocal divide that splits total_length into packets.
module gbn_cfg #(
  parameter int unsigned PACKET_BYTES = gbn_pkg::PacketBytes
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  gbn_cfg_if.sink        cfg_ch,
  output gbn_pkg::cfg_t  cfg_o,
  output logic           busy_o
);

  localparam int unsigned RemW  = $clog2(PACKET_BYTES + 1);
  localparam int unsigned Shift = gbn_pkg::TotalW + $clog2(PACKET_BYTES);
  localparam int unsigned RcpW  = gbn_pkg::TotalW + 2;
  localparam int unsigned ProdW = gbn_pkg::TotalW + RcpW;
  localparam int unsigned MulW  = gbn_pkg::TotalW + RemW;
  localparam longint unsigned Recip =
    ((64'd1 << Shift) + 64'(PACKET_BYTES) - 64'd1) / 64'(PACKET_BYTES);

  logic [5:0]                    window_q, window_d;
  logic [gbn_pkg::TotalW-1:0]    total_q, total_d;
  logic [7:0]                    tries_q, tries_d;
  logic [gbn_pkg::TotalW-1:0]    quo_q, quo_d;
  logic [RemW-1:0]               rem_q, rem_d;
  logic [1:0]                    cnt_q, cnt_d;

  logic [ProdW-1:0] prod;
  logic [MulW-1:0]  quo_mul;
  logic             busy;
  logic             wr;

  assign busy         = (cnt_q != '0);
  assign busy_o       = busy;
  assign cfg_ch.ready = !busy;
  assign wr           = cfg_ch.valid && !busy;

  // reciprocal-multiply quotient, exact for every 24-bit length; remainder next cycle
  assign prod    = ProdW'(total_q) * ProdW'(Recip);
  assign quo_mul = MulW'(quo_q) * MulW'(PACKET_BYTES);

  always_comb begin
    window_d = window_q;
    total_d  = total_q;
    tries_d  = tries_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    if (busy) begin
      if (cnt_q == 2'd2) begin
        quo_d = gbn_pkg::TotalW'(prod >> Shift);
      end else begin
        rem_d = RemW'(MulW'(total_q) - quo_mul);
      end
      cnt_d = cnt_q - 2'd1;
    end else if (wr) begin
      case (cfg_ch.index)
        gbn_pkg::CfgWindow: window_d = cfg_ch.data[5:0];
        gbn_pkg::CfgTotal: begin
          total_d = cfg_ch.data;
          cnt_d   = 2'd2;
        end
        gbn_pkg::CfgTries: tries_d = cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= gbn_pkg::WindowReset;
      total_q  <= '0;
      tries_q  <= gbn_pkg::TriesReset;
      quo_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
    end else begin
      window_q <= window_d;
      total_q  <= total_d;
      tries_q  <= tries_d;
      quo_q    <= quo_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
    end
  end

  assign cfg_o.window_size  = window_q;
  assign cfg_o.total_length = total_q;
  assign cfg_o.max_tries    = tries_q;
  assign cfg_o.last_index   = quo_q;
  assign cfg_o.tail_bytes   = gbn_pkg::TailW'(rem_q);

endmodule

// File: src/gbn_front.sv
// Input side: takes event items and turns them into commands for the queue.
module gbn_front (
  gbn_in_if.sink         in_ch,
  input  logic           busy_i,
  input  logic           full_i,
  output logic           push_o,
  output gbn_pkg::cmd_t  cmd_o
);

  assign in_ch.ready = !full_i && !busy_i;
  assign push_o      = in_ch.valid && in_ch.ready;

  always_comb begin
    cmd_o.ack = in_ch.ack_number;
    unique case (in_ch.func)
      gbn_pkg::FuncPoll:    cmd_o.op = gbn_pkg::CMD_POLL;
      gbn_pkg::FuncAck:     cmd_o.op = gbn_pkg::CMD_ACK;
      gbn_pkg::FuncTimeout: cmd_o.op = gbn_pkg::CMD_TIMEOUT;
      default:              cmd_o.op = gbn_pkg::CMD_IDLE;
    endcase
  end

endmodule

// File: src/gbn_queue.sv
// Short command queue between the input side and the sequencer.
module gbn_queue #(
  parameter int unsigned DEPTH = gbn_pkg::CmdDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gbn_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output gbn_pkg::cmd_t  cmd_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  gbn_pkg::cmd_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: src/gbn_back.sv
// Sequencer: holds the window state, carries out commands and drives the result register.
module gbn_back #(
  parameter int unsigned PACKET_BYTES = gbn_pkg::PacketBytes,
  parameter int unsigned MAX_WINDOW   = gbn_pkg::MaxWindow
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gbn_pkg::cfg_t  cfg_i,
  input  gbn_pkg::cmd_t  cmd_i,
  input  logic           empty_i,
  output logic           pop_o,
  gbn_out_if.source      out_ch
);

  localparam int unsigned NW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned OffW = 25 + $clog2(PACKET_BYTES + 1);
  localparam int unsigned SeqW = gbn_pkg::SeqW;
  localparam int unsigned WinW = gbn_pkg::WinW;

  gbn_pkg::back_state_e state_q, state_d;
  logic [SeqW-1:0]  base_q, base_d;
  logic [SeqW-1:0]  ns_q, ns_d;
  logic [7:0]       try_q, try_d;
  logic             full_q, full_d;
  logic [SeqW:0]    aw_q, aw_d;
  logic [NW-1:0]    n_q, n_d;
  logic             out_valid_q;
  gbn_pkg::result_t out_q, res_d;
  logic             load;

  logic                    slot_free;
  logic [WinW-1:0]         w_eff;
  logic [SeqW-1:0]         diff, diff_next;
  logic                    in_win, in_win_next, tries_ok, n_ok, n_ok_next;
  logic                    send_ok, next_ok, fits;
  logic [OffW-1:0]         off_w;
  logic [gbn_pkg::TailW-1:0] cur;
  logic [7:0]              try_inc;
  logic [SeqW:0]           ack_d, ack_p1;
  logic                    acc, ack_done, comp;

  assign slot_free = !out_valid_q || out_ch.ready;

  // window, clamped to the build-time maximum
  assign w_eff = ({1'b0, cfg_i.window_size} > WinW'(MAX_WINDOW)) ? WinW'(MAX_WINDOW)
                                                                : {1'b0, cfg_i.window_size};
  assign diff        = ns_q - base_q;
  assign diff_next   = diff + SeqW'(1);
  assign in_win      = diff < SeqW'(w_eff);
  assign in_win_next = diff_next < SeqW'(w_eff);
  assign tries_ok    = try_q < cfg_i.max_tries;
  assign n_ok        = n_q < NW'(MAX_WINDOW);
  assign n_ok_next   = ({1'b0, n_q} + (NW+1)'(1)) < (NW+1)'(MAX_WINDOW);

  assign off_w = OffW'(ns_q) * OffW'(PACKET_BYTES);
  assign fits  = (off_w + OffW'(PACKET_BYTES)) <= OffW'(cfg_i.total_length);
  assign cur   = fits ? gbn_pkg::TailW'(PACKET_BYTES) : cfg_i.tail_bytes;

  assign send_ok = in_win && tries_ok && full_q && n_ok;
  assign next_ok = in_win_next && tries_ok && fits && n_ok_next;

  assign try_inc = (try_q == gbn_pkg::TriesSat) ? try_q : try_q + 8'd1;

  // ack accepted when within one of the ack window, either side
  assign ack_d    = aw_q - {1'b0, cmd_i.ack};
  assign acc      = (ack_d == '0) || (ack_d == (SeqW+1)'(1)) || (ack_d == '1);
  assign ack_p1   = {1'b0, cmd_i.ack} + (SeqW+1)'(1);
  assign ack_done = (ack_p1[SeqW-1:0] == ns_q);
  assign comp     = ({8'd0, cmd_i.ack} == cfg_i.last_index);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbn_pkg::ST_IDLE: begin
        if (!empty_i && cmd_i.op == gbn_pkg::CMD_POLL) begin
          state_d = gbn_pkg::ST_POLL;
        end
      end
      gbn_pkg::ST_POLL: begin
        if (slot_free && (!send_ok || !next_ok)) begin
          state_d = gbn_pkg::ST_IDLE;
        end
      end
      default: state_d = gbn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = 1'b0;
    load   = 1'b0;
    base_d = base_q;
    ns_d   = ns_q;
    try_d  = try_q;
    full_d = full_q;
    aw_d   = aw_q;
    n_d    = n_q;
    res_d  = '0;
    res_d.kind       = gbn_pkg::KindStatus;
    res_d.seq_number = base_q;
    res_d.give_up    = (try_q >= cfg_i.max_tries);
    res_d.last       = 1'b1;
    unique case (state_q)
      gbn_pkg::ST_IDLE: begin
        if (!empty_i) begin
          if (cmd_i.op == gbn_pkg::CMD_POLL) begin
            pop_o = 1'b1;
            n_d   = '0;
          end else if (slot_free) begin
            pop_o = 1'b1;
            load  = 1'b1;
            unique case (cmd_i.op)
              gbn_pkg::CMD_ACK: begin
                res_d.kind       = gbn_pkg::KindAck;
                res_d.seq_number = cmd_i.ack;
                res_d.give_up    = 1'b0;
                res_d.accepted   = acc;
                res_d.complete   = comp;
                if (acc) begin
                  base_d = ack_p1[SeqW-1:0];
                  if (ack_done) begin
                    aw_d             = {1'b0, cmd_i.ack};
                    try_d            = '0;
                    res_d.stop_timer = 1'b1;
                  end else begin
                    aw_d              = ack_p1;
                    res_d.start_timer = 1'b1;
                  end
                end
              end
              gbn_pkg::CMD_TIMEOUT: begin
                ns_d          = base_q;
                full_d        = 1'b1;
                try_d         = try_inc;
                res_d.give_up = (try_inc >= cfg_i.max_tries);
              end
              default: ;
            endcase
          end
        end
      end
      gbn_pkg::ST_POLL: begin
        if (slot_free) begin
          load = 1'b1;
          if (send_ok) begin
            res_d.kind        = gbn_pkg::KindDesc;
            res_d.seq_number  = ns_q;
            res_d.byte_offset = off_w[23:0];
            res_d.length      = cur[10:0];
            res_d.start_timer = (base_q == ns_q);
            res_d.give_up     = 1'b0;
            res_d.last        = !next_ok;
            ns_d   = ns_q + SeqW'(1);
            full_d = fits;
            n_d    = n_q + NW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbn_pkg::ST_IDLE;
      base_q      <= '0;
      ns_q        <= '0;
      try_q       <= '0;
      full_q      <= 1'b1;
      aw_q        <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      ns_q    <= ns_d;
      try_q   <= try_d;
      full_q  <= full_d;
      aw_q    <= aw_d;
      n_q     <= n_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.kind        = out_q.kind;
  assign out_ch.seq_number  = out_q.seq_number;
  assign out_ch.byte_offset = out_q.byte_offset;
  assign out_ch.length      = out_q.length;
  assign out_ch.start_timer = out_q.start_timer;
  assign out_ch.stop_timer  = out_q.stop_timer;
  assign out_ch.accepted    = out_q.accepted;
  assign out_ch.complete    = out_q.complete;
  assign out_ch.give_up     = out_q.give_up;
  assign out_ch.last        = out_q.last;

endmodule

// File: src/go_back_n_sender.sv
// An ack, timeout or unknown event drives its result item via the result register once popped.
// A send poll is popped into the poll state, then gives one result item per cycle while the
// output is free (up to MAX_WINDOW descriptors, or a single status item). Events queue two
// deep ahead of the sequencer; throughput is one single-result event a cycle while the output
// is free and no divide runs. Reset: window 5, length 0, try limit 8, state cleared. A
// total_length write runs a divide during which the event and register ports are not ready.
module go_back_n_sender #(
  parameter int unsigned PACKET_BYTES = gbn_pkg::PacketBytes,
  parameter int unsigned MAX_WINDOW   = gbn_pkg::MaxWindow
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbn_in_if.sink     in_ch,
  gbn_out_if.source  out_ch,
  gbn_cfg_if.sink    cfg_ch
);

  gbn_pkg::cfg_t cfg;
  gbn_pkg::cmd_t push_cmd, head_cmd;
  logic          busy, full, push, pop, empty;

  gbn_cfg #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg),
    .busy_o (busy)
  );

  gbn_front u_front (
    .in_ch  (in_ch),
    .busy_i (busy),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  gbn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty)
  );

  gbn_back #(
    .PACKET_BYTES(PACKET_BYTES),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .cmd_i   (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule
